/* rtl/rrfpm_pkg.sv */
// ----------------------------------------------------------------------------
// rrfpm_pkg
// Shared types and constants of the six-pipe radio register file: action
// codes, register addresses, reset values and the structs between modules.
// ----------------------------------------------------------------------------
package rrfpm_pkg;

   // pipe slots the register map provides
   localparam int PIPE_SLOTS    = 6;

   // action codes
   localparam logic [3:0] ACT_READ      = 4'd0;
   localparam logic [3:0] ACT_WRITE     = 4'd1;
   localparam logic [3:0] ACT_MATCH     = 4'd2;
   localparam logic [3:0] ACT_LOOKUP    = 4'd3;
   localparam logic [3:0] ACT_LOST_INC  = 4'd4;
   localparam logic [3:0] ACT_RETRY_INC = 4'd5;
   localparam logic [3:0] ACT_TXFULL_SET = 4'd6;
   localparam logic [3:0] ACT_TXFULL_CLR = 4'd7;
   localparam logic [3:0] ACT_CE_HIGH   = 4'd8;
   localparam logic [3:0] ACT_CE_LOW    = 4'd9;

   // register addresses
   localparam logic [4:0] REG_CONFIG      = 5'h00;
   localparam logic [4:0] REG_EN_AA       = 5'h01;
   localparam logic [4:0] REG_EN_RXADDR   = 5'h02;
   localparam logic [4:0] REG_SETUP_AW    = 5'h03;
   localparam logic [4:0] REG_RF_CH       = 5'h05;
   localparam logic [4:0] REG_RF_SETUP    = 5'h06;
   localparam logic [4:0] REG_STATUS      = 5'h07;
   localparam logic [4:0] REG_OBSERVE_TX  = 5'h08;
   localparam logic [4:0] REG_RPD         = 5'h09;
   localparam logic [4:0] REG_RX_ADDR_P0  = 5'h0A;
   localparam logic [4:0] REG_RX_ADDR_P1  = 5'h0B;
   localparam logic [4:0] REG_RX_ADDR_P2  = 5'h0C;
   localparam logic [4:0] REG_RX_ADDR_P5  = 5'h0F;
   localparam logic [4:0] REG_TX_ADDR     = 5'h10;
   localparam logic [4:0] REG_RX_PW_P0    = 5'h11;
   localparam logic [4:0] REG_RX_PW_P5    = 5'h16;
   localparam logic [4:0] REG_FIFO_STATUS = 5'h17;
   localparam logic [4:0] REG_DYNPD       = 5'h1C;
   localparam logic [4:0] REG_FEATURE     = 5'h1D;

   // reset values
   localparam logic [7:0]  RST_CONFIG      = 8'h08;
   localparam logic [5:0]  RST_EN_AA       = 6'h3F;
   localparam logic [5:0]  RST_EN_RXADDR   = 6'h03;
   localparam logic [7:0]  RST_SETUP_AW    = 8'h03;
   localparam logic [7:0]  RST_SETUP_RETR  = 8'h03;
   localparam logic [7:0]  RST_RF_CH       = 8'h02;
   localparam logic [7:0]  RST_RF_SETUP    = 8'h0E;
   localparam logic [7:0]  RST_STATUS      = 8'h0E;
   localparam logic [39:0] RST_ADDR_P0     = 40'hE7E7E7E7E7;
   localparam logic [39:0] RST_ADDR_P1     = 40'hC2C2C2C2C2;
   localparam logic [39:0] RST_ADDR_TX     = 40'hE7E7E7E7E7;
   localparam logic [7:0]  RST_LOW_P2      = 8'hC3;
   localparam logic [7:0]  RST_LOW_P3      = 8'hC4;
   localparam logic [7:0]  RST_LOW_P4      = 8'hC5;
   localparam logic [7:0]  RST_LOW_P5      = 8'hC6;
   localparam logic [7:0]  RST_FIFO_STATUS = 8'h11;

   // status flag bits (RX_DR, TX_DS, MAX_RT), cleared by writing one
   localparam logic [7:0] STATUS_IRQ_MASK = 8'h70;
   localparam logic [3:0] COUNT_MAX       = 4'hF;
   localparam logic [2:0] NO_MATCH        = 3'd7;

   // one request item
   typedef struct packed {
      logic [3:0]  action;
      logic [4:0]  reg_addr;
      logic [39:0] write_data;
      logic [39:0] rx_address;
      logic [2:0]  pipe_index;
      logic        need_auto_ack;
   } req_type;

   // register contents the address matcher needs
   typedef struct packed {
      logic [5:0]       pipe_en;
      logic [5:0]       auto_ack;
      logic [39:0]      addr_p0;
      logic [39:0]      addr_p1;
      logic [3:0][7:0]  low_byte;
   } pipe_view_type;

   // per-step flags from the register bank
   typedef struct packed {
      logic irq_active;
      logic mode_changed;
      logic power_changed;
      logic chip_enable_changed;
      logic chip_enable;
   } reg_flags_type;

endpackage

/* rtl/rrfpm_regs.sv */
// ----------------------------------------------------------------------------
// rrfpm_regs
// Register bank: read mux, masked writes, counters, TX-full and chip-enable
// updates. State changes at the edge where a step commits.
// ----------------------------------------------------------------------------
module rrfpm_regs
   import rrfpm_pkg::*;
#(
   parameter int ADDRESS_BITS = 40
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          step_valid,
   input  req_type       cmd,
   output logic [39:0]   read_data,
   output pipe_view_type view,
   output reg_flags_type flags
);

   logic [7:0]              config_ff,   config_in;
   logic [5:0]              aa_ff,       aa_in;
   logic [5:0]              en_ff,       en_in;
   logic [7:0]              misc_ff [4];
   logic [7:0]              misc_in [4];
   logic [7:0]              status_ff,   status_in;
   logic [7:0]              observe_ff,  observe_in;
   logic [ADDRESS_BITS-1:0] addr_p0_ff,  addr_p0_in;
   logic [ADDRESS_BITS-1:0] addr_p1_ff,  addr_p1_in;
   logic [ADDRESS_BITS-1:0] addr_tx_ff,  addr_tx_in;
   logic [7:0]              low_ff [4];
   logic [7:0]              low_in [4];
   logic [5:0]              pw_ff [6];
   logic [5:0]              pw_in [6];
   logic [7:0]              fifo_ff,     fifo_in;
   logic [7:0]              dyn_ff [2];
   logic [7:0]              dyn_in [2];
   logic                    ce_ff,       ce_in;

   logic [7:0]  wbyte;
   logic [1:0]  misc_idx;
   logic [2:0]  pw_idx;
   logic [39:0] rd_mux;

   assign wbyte    = cmd.write_data[7:0];
   assign misc_idx = 2'(cmd.reg_addr - REG_SETUP_AW);
   assign pw_idx   = 3'(cmd.reg_addr - REG_RX_PW_P0);

   // next state and step flags
   always_comb begin
      config_in  = config_ff;
      aa_in      = aa_ff;
      en_in      = en_ff;
      misc_in    = misc_ff;
      status_in  = status_ff;
      observe_in = observe_ff;
      addr_p0_in = addr_p0_ff;
      addr_p1_in = addr_p1_ff;
      addr_tx_in = addr_tx_ff;
      low_in     = low_ff;
      pw_in      = pw_ff;
      fifo_in    = fifo_ff;
      dyn_in     = dyn_ff;
      ce_in      = ce_ff;
      flags.mode_changed        = 1'b0;
      flags.power_changed       = 1'b0;
      flags.chip_enable_changed = 1'b0;
      if (step_valid) begin
         case (cmd.action)
            ACT_WRITE: begin
               unique case (cmd.reg_addr) inside
                  REG_CONFIG: begin
                     flags.mode_changed  = config_ff[0] ^ wbyte[0];
                     flags.power_changed = config_ff[1] ^ wbyte[1];
                     config_in = wbyte;
                  end
                  REG_EN_AA:     aa_in = wbyte[5:0];
                  REG_EN_RXADDR: en_in = wbyte[5:0];
                  [REG_SETUP_AW:REG_RF_SETUP]: begin
                     misc_in[misc_idx] = wbyte;
                     // a channel write clears the lost-packet count
                     if (cmd.reg_addr == REG_RF_CH) observe_in[7:4] = 4'h0;
                  end
                  REG_STATUS:     status_in = status_ff & ~(wbyte & STATUS_IRQ_MASK);
                  REG_RX_ADDR_P0: addr_p0_in = cmd.write_data[ADDRESS_BITS-1:0];
                  REG_RX_ADDR_P1: addr_p1_in = cmd.write_data[ADDRESS_BITS-1:0];
                  [REG_RX_ADDR_P2:REG_RX_ADDR_P5]: low_in[cmd.reg_addr[1:0]] = wbyte;
                  REG_TX_ADDR:    addr_tx_in = cmd.write_data[ADDRESS_BITS-1:0];
                  [REG_RX_PW_P0:REG_RX_PW_P5]: pw_in[pw_idx] = wbyte[5:0];
                  REG_DYNPD, REG_FEATURE: dyn_in[cmd.reg_addr[0]] = wbyte;
                  default: ; // read-only or unmapped
               endcase
            end
            ACT_LOST_INC: begin
               if (observe_ff[7:4] != COUNT_MAX) observe_in[7:4] = observe_ff[7:4] + 4'd1;
            end
            ACT_RETRY_INC: begin
               if (observe_ff[3:0] != COUNT_MAX) observe_in[3:0] = observe_ff[3:0] + 4'd1;
            end
            ACT_TXFULL_SET: begin
               fifo_in[5]   = 1'b1;
               status_in[0] = 1'b1;
            end
            ACT_TXFULL_CLR: begin
               fifo_in[5]   = 1'b0;
               status_in[0] = 1'b0;
            end
            ACT_CE_HIGH: begin
               ce_in = 1'b1;
               flags.chip_enable_changed = !ce_ff;
            end
            ACT_CE_LOW: begin
               ce_in = 1'b0;
               flags.chip_enable_changed = ce_ff;
            end
            default: ;
         endcase
      end
      // levels after the step
      flags.irq_active  = |(status_in & ~config_in & STATUS_IRQ_MASK);
      flags.chip_enable = ce_in;
   end

   // read mux over the current contents
   always_comb begin
      unique case (cmd.reg_addr) inside
         REG_CONFIG:     rd_mux = 40'(config_ff);
         REG_EN_AA:      rd_mux = 40'(aa_ff);
         REG_EN_RXADDR:  rd_mux = 40'(en_ff);
         [REG_SETUP_AW:REG_RF_SETUP]: rd_mux = 40'(misc_ff[misc_idx]);
         REG_STATUS:     rd_mux = 40'(status_ff);
         REG_OBSERVE_TX: rd_mux = 40'(observe_ff);
         REG_RX_ADDR_P0: rd_mux = 40'(addr_p0_ff);
         REG_RX_ADDR_P1: rd_mux = 40'(addr_p1_ff);
         [REG_RX_ADDR_P2:REG_RX_ADDR_P5]: rd_mux = 40'(low_ff[cmd.reg_addr[1:0]]);
         REG_TX_ADDR:    rd_mux = 40'(addr_tx_ff);
         [REG_RX_PW_P0:REG_RX_PW_P5]: rd_mux = 40'(pw_ff[pw_idx]);
         REG_FIFO_STATUS: rd_mux = 40'(fifo_ff);
         REG_DYNPD, REG_FEATURE: rd_mux = 40'(dyn_ff[cmd.reg_addr[0]]);
         default:        rd_mux = '0; // power detect and unmapped
      endcase
   end

   assign read_data = (cmd.action == ACT_READ) ? rd_mux : '0;

   // view for the matcher
   assign view.pipe_en  = en_ff;
   assign view.auto_ack = aa_ff;
   assign view.addr_p0  = 40'(addr_p0_ff);
   assign view.addr_p1  = 40'(addr_p1_ff);
   assign view.low_byte = {low_ff[3], low_ff[2], low_ff[1], low_ff[0]};

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         config_ff  <= RST_CONFIG;
         aa_ff      <= RST_EN_AA;
         en_ff      <= RST_EN_RXADDR;
         misc_ff[0] <= RST_SETUP_AW;
         misc_ff[1] <= RST_SETUP_RETR;
         misc_ff[2] <= RST_RF_CH;
         misc_ff[3] <= RST_RF_SETUP;
         status_ff  <= RST_STATUS;
         observe_ff <= '0;
         addr_p0_ff <= RST_ADDR_P0[ADDRESS_BITS-1:0];
         addr_p1_ff <= RST_ADDR_P1[ADDRESS_BITS-1:0];
         addr_tx_ff <= RST_ADDR_TX[ADDRESS_BITS-1:0];
         low_ff[0]  <= RST_LOW_P2;
         low_ff[1]  <= RST_LOW_P3;
         low_ff[2]  <= RST_LOW_P4;
         low_ff[3]  <= RST_LOW_P5;
         for (int i = 0; i < 6; i++) begin
            pw_ff[i] <= '0;
         end
         fifo_ff    <= RST_FIFO_STATUS;
         dyn_ff[0]  <= '0;
         dyn_ff[1]  <= '0;
         ce_ff      <= 1'b0;
      end else begin
         config_ff  <= config_in;
         aa_ff      <= aa_in;
         en_ff      <= en_in;
         misc_ff    <= misc_in;
         status_ff  <= status_in;
         observe_ff <= observe_in;
         addr_p0_ff <= addr_p0_in;
         addr_p1_ff <= addr_p1_in;
         addr_tx_ff <= addr_tx_in;
         low_ff     <= low_in;
         pw_ff      <= pw_in;
         fifo_ff    <= fifo_in;
         dyn_ff     <= dyn_in;
         ce_ff      <= ce_in;
      end
   end

endmodule

/* rtl/rrfpm_match.sv */
// ----------------------------------------------------------------------------
// rrfpm_match
// Address compare against all enabled pipes in parallel, lowest pipe wins,
// and pipe-to-address lookup with optional auto-ack requirement.
// ----------------------------------------------------------------------------
module rrfpm_match
   import rrfpm_pkg::*;
#(
   parameter int ADDRESS_BITS = 40,
   parameter int NUM_PIPES    = 6
) (
   input  req_type       cmd,
   input  pipe_view_type view,
   output logic [2:0]    matched_pipe,
   output logic [39:0]   lookup_addr,
   output logic          auto_ack_on
);

   logic [ADDRESS_BITS-1:0] full_addr [PIPE_SLOTS];

   // pipes 2..5 borrow the upper bytes of pipe 1
   always_comb begin
      full_addr[0] = view.addr_p0[ADDRESS_BITS-1:0];
      full_addr[1] = view.addr_p1[ADDRESS_BITS-1:0];
      for (int p = 2; p < PIPE_SLOTS; p++) begin
         full_addr[p] = {view.addr_p1[ADDRESS_BITS-1:8], view.low_byte[p-2]};
      end
   end

   // priority match, scanned so the lowest pipe is assigned last
   always_comb begin
      matched_pipe = NO_MATCH;
      if (cmd.action == ACT_MATCH) begin
         for (int p = PIPE_SLOTS - 1; p >= 0; p--) begin
            if (p < NUM_PIPES && view.pipe_en[p] &&
                full_addr[p] == cmd.rx_address[ADDRESS_BITS-1:0]) begin
               matched_pipe = 3'(p);
            end
         end
      end
   end

   // lookup; absent pipes give zero
   always_comb begin
      lookup_addr = '0;
      auto_ack_on = 1'b0;
      if (cmd.action == ACT_LOOKUP) begin
         for (int p = 0; p < PIPE_SLOTS; p++) begin
            if (p < NUM_PIPES && cmd.pipe_index == 3'(p)) begin
               auto_ack_on = view.auto_ack[p];
               if (view.pipe_en[p] && (!cmd.need_auto_ack || view.auto_ack[p])) begin
                  lookup_addr = 40'(full_addr[p]);
               end
            end
         end
      end
   end

endmodule

/* rtl/radio_register_file_pipe_match_core.sv */
// ----------------------------------------------------------------------------
// radio_register_file_pipe_match_core
// Register file of a six-pipe radio transceiver with address matching.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the req_ stream: tuser carries the action, tdata the
//   operands. Every request yields exactly one transfer on the rsp_ stream.
//   A request is registered at its transfer, processed against the register
//   bank once the output register is free or being read, and the result
//   lands in the output register, which drives rsp_tvalid.
//   Throughput is one request per cycle while the receiver takes responses;
//   the register bank updates in the same cycle the result is formed, so
//   the next request sees the new state.
//   When the receiver stalls the output register holds its result and the
//   input register holds one more request; req_tready then drops.
//   Reset clears both pipeline stages and loads the register defaults
//   (CONFIG 0x08, STATUS 0x0E, pipe addresses E7.., C2.., C3..C6).
//   ADDRESS_BITS sets the stored pipe address width, NUM_PIPES the number
//   of pipes that take part in matching and lookup.
// ----------------------------------------------------------------------------
module radio_register_file_pipe_match_core
   import rrfpm_pkg::*;
#(
   parameter int ADDRESS_BITS = 40,
   parameter int NUM_PIPES    = 6
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [4:0] reg_addr, [44:5] write_data, [84:45] rx_address,
   // [87:85] pipe_index, [88] need_auto_ack, [95:89] zero
   input  logic [95:0] req_tdata,
   // [3:0] action
   input  logic [3:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [39:0] read_data, [42:40] matched_pipe, [82:43] pipe address,
   // [83] auto_ack_on, [84] irq_active, [85] mode_changed,
   // [86] power_changed, [87] chip_enable_changed, [88] chip_enable,
   // [95:89] zero
   output logic [95:0] rsp_tdata
);

   logic          in_valid_ff, in_valid_in;
   req_type       in_ff;
   logic          out_valid_ff, out_valid_in;
   logic [95:0]   out_ff, out_in;
   logic          step;

   logic [39:0]   read_data;
   logic [2:0]    matched_pipe;
   logic [39:0]   lookup_addr;
   logic          auto_ack_on;
   pipe_view_type view;
   reg_flags_type flags;

   // stage handshake
   assign step         = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready   = !in_valid_ff || step;
   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !step);
   assign out_valid_in = step || (out_valid_ff && !rsp_tready);

   rrfpm_regs #(
      .ADDRESS_BITS (ADDRESS_BITS)
   ) u_regs (
      .clock      (clock),
      .reset      (reset),
      .step_valid (step),
      .cmd        (in_ff),
      .read_data  (read_data),
      .view       (view),
      .flags      (flags)
   );

   rrfpm_match #(
      .ADDRESS_BITS (ADDRESS_BITS),
      .NUM_PIPES    (NUM_PIPES)
   ) u_match (
      .cmd          (in_ff),
      .view         (view),
      .matched_pipe (matched_pipe),
      .lookup_addr  (lookup_addr),
      .auto_ack_on  (auto_ack_on)
   );

   // result packing
   assign out_in = {7'd0, flags.chip_enable, flags.chip_enable_changed,
                    flags.power_changed, flags.mode_changed, flags.irq_active,
                    auto_ack_on, lookup_addr, matched_pipe, read_data};

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_ff.action        <= req_tuser;
         in_ff.reg_addr      <= req_tdata[4:0];
         in_ff.write_data    <= req_tdata[44:5];
         in_ff.rx_address    <= req_tdata[84:45];
         in_ff.pipe_index    <= req_tdata[87:85];
         in_ff.need_auto_ack <= req_tdata[88];
      end
      if (step) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;

endmodule

/* rtl/rrfpm_checker.sv */
// ----------------------------------------------------------------------------
// rrfpm_checker
// Port-level checks of the register file core, bound to the top level.
// ----------------------------------------------------------------------------
module rrfpm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [95:0] req_tdata,
   input logic [3:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [95:0] rsp_tdata
);

   // nothing comes out right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // a match result excludes read, lookup and change flags
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[42:40] != 3'd7 |->
         rsp_tdata[39:0] == 40'd0 && rsp_tdata[82:43] == 40'd0 &&
         rsp_tdata[87:85] == 3'd0)
      else $error("match result mixed with other action results");

   // a config change flag comes only from a write: no other result fields
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[85] || rsp_tdata[86]) |->
         rsp_tdata[39:0] == 40'd0 && rsp_tdata[42:40] == 3'd7 &&
         rsp_tdata[83:43] == 41'd0 && !rsp_tdata[87])
      else $error("config change flag with foreign results");

   // padding bits stay zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[95:89] == 7'd0)
      else $error("response padding not zero");

endmodule

bind radio_register_file_pipe_match_core rrfpm_checker u_checker (.*);

/* tb/radio_register_file_pipe_match_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radio_register_file_pipe_match_core_test
// Self-checking bench for the radio register file. A queue of requests feeds
// a clocked stream driver, and each accepted transfer is run through a local
// mirror of the register bank that gives the expected response. A clocked
// monitor compares every response transfer field by field, in order.
// Traffic is a short directed set, then random register programming with
// address-match and lookup bursts, counter bursts and noise, under changing
// backpressure.
// ----------------------------------------------------------------------------
module radio_register_file_pipe_match_core_test;
   import rrfpm_pkg::*;

   // addresses and an action code the package does not name
   localparam logic [4:0] REG_UNMAPPED_LO = 5'h18;
   localparam logic [4:0] REG_UNMAPPED_HI = 5'h1F;
   localparam logic [3:0] ACT_UNUSED_HI   = 4'hF;

   localparam int RANDOM_OPS  = 1250;
   localparam int DRAIN_EVERY = 450;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PRINT_LIMIT = 40;

   // response fields, lowest bits last
   typedef struct packed {
      logic        chip_enable;
      logic        chip_enable_changed;
      logic        power_changed;
      logic        mode_changed;
      logic        irq_active;
      logic        auto_ack_on;
      logic [39:0] lookup_addr;
      logic [2:0]  matched_pipe;
      logic [39:0] read_data;
   } radio_rsp_type;

   // queued request; drain holds it back until all responses are in
   typedef struct {
      req_type op;
      bit      drain;
   } radio_item_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [95:0] req_tdata  = '0;
   logic [3:0]  req_tuser  = '0;
   logic        rsp_tready = 1'b0;
   wire         req_tready;
   wire         rsp_tvalid;
   wire  [95:0] rsp_tdata;

   radio_register_file_pipe_match_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // register bank mirror
   logic [7:0]  cfg_r, status_r, observe_r, fifo_r;
   logic [5:0]  en_aa_r, en_rx_r;
   logic [7:0]  setup_r [4];
   logic [39:0] wide_r [3];
   logic [7:0]  low_r [4];
   logic [5:0]  rx_pw_r [6];
   logic [7:0]  dyn_r [2];
   logic        ce_r;

   // pipe addresses as the generator has programmed them
   logic [39:0] gen_p0, gen_p1;
   logic [7:0]  gen_low [4];
   bit          hold_next = 0;

   radio_item_type pending_ops[$];
   radio_rsp_type  expected_rsps[$];
   req_type        cur_op;
   int             errors     = 0;
   int             ops_sent   = 0;
   int             total_ops  = 1;
   int             cycles     = 0;
   int             send_idle  = 0;
   int             recv_idle  = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      errors++;
      if (errors <= PRINT_LIMIT)
         $display("%0t ERROR: %s", $time, msg);
   endtask

   function automatic logic [39:0] rand40();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[39:0];
   endfunction

   function automatic logic [4:0] rand_reg();
      return 5'($urandom_range(0, 31));
   endfunction

   function automatic logic [2:0] rand_pipe();
      return 3'($urandom_range(0, 7));
   endfunction

   function automatic logic rand_bit();
      return 1'($urandom_range(0, 1));
   endfunction

   // full address of a pipe in the mirror; pipes 2..5 borrow pipe 1's top
   function automatic logic [39:0] pipe_full_addr(input int p);
      if (p == 0) return wide_r[0];
      if (p == 1) return wide_r[1];
      return {wide_r[1][39:8], low_r[p - 2]};
   endfunction

   function automatic logic [39:0] gen_pipe(input int p);
      if (p == 0) return gen_p0;
      if (p == 1) return gen_p1;
      return {gen_p1[39:8], gen_low[p - 2]};
   endfunction

   // one request against the mirror, giving the response it must produce
   task automatic radio_regs_step(input req_type op, output radio_rsp_type res);
      logic [7:0] b;
      logic [4:0] a;
      int         p;
      bit         hit;
      res = '0;
      res.matched_pipe = NO_MATCH;
      b = op.write_data[7:0];
      a = op.reg_addr;
      hit = 0;
      case (op.action)
         ACT_READ: begin
            if (a == REG_CONFIG) res.read_data = 40'(cfg_r);
            else if (a == REG_EN_AA) res.read_data = 40'(en_aa_r);
            else if (a == REG_EN_RXADDR) res.read_data = 40'(en_rx_r);
            else if (a >= REG_SETUP_AW && a <= REG_RF_SETUP)
               res.read_data = 40'(setup_r[2'(a - REG_SETUP_AW)]);
            else if (a == REG_STATUS) res.read_data = 40'(status_r);
            else if (a == REG_OBSERVE_TX) res.read_data = 40'(observe_r);
            else if (a == REG_RX_ADDR_P0 || a == REG_RX_ADDR_P1)
               res.read_data = wide_r[2'(a - REG_RX_ADDR_P0)];
            else if (a >= REG_RX_ADDR_P2 && a <= REG_RX_ADDR_P5)
               res.read_data = 40'(low_r[a[1:0]]);
            else if (a == REG_TX_ADDR) res.read_data = wide_r[2];
            else if (a >= REG_RX_PW_P0 && a <= REG_RX_PW_P5)
               res.read_data = 40'(rx_pw_r[3'(a - REG_RX_PW_P0)]);
            else if (a == REG_FIFO_STATUS) res.read_data = 40'(fifo_r);
            else if (a == REG_DYNPD || a == REG_FEATURE)
               res.read_data = 40'(dyn_r[a[0]]);
         end
         ACT_WRITE: begin
            // observe, power detect and fifo status ignore writes
            if (a == REG_CONFIG) begin
               res.mode_changed  = cfg_r[0] ^ b[0];
               res.power_changed = cfg_r[1] ^ b[1];
               cfg_r = b;
            end else if (a == REG_EN_AA) en_aa_r = b[5:0];
            else if (a == REG_EN_RXADDR) en_rx_r = b[5:0];
            else if (a >= REG_SETUP_AW && a <= REG_RF_SETUP) begin
               setup_r[2'(a - REG_SETUP_AW)] = b;
               // channel write clears the lost-packet count
               if (a == REG_RF_CH) observe_r[7:4] = 4'd0;
            end else if (a == REG_STATUS) status_r = status_r & ~(b & STATUS_IRQ_MASK);
            else if (a == REG_RX_ADDR_P0 || a == REG_RX_ADDR_P1)
               wide_r[2'(a - REG_RX_ADDR_P0)] = op.write_data;
            else if (a >= REG_RX_ADDR_P2 && a <= REG_RX_ADDR_P5)
               low_r[a[1:0]] = b;
            else if (a == REG_TX_ADDR) wide_r[2] = op.write_data;
            else if (a >= REG_RX_PW_P0 && a <= REG_RX_PW_P5)
               rx_pw_r[3'(a - REG_RX_PW_P0)] = b[5:0];
            else if (a == REG_DYNPD || a == REG_FEATURE) dyn_r[a[0]] = b;
         end
         ACT_MATCH: begin
            // lowest enabled pipe wins
            for (p = 0; p < PIPE_SLOTS; p++) begin
               if (!hit && en_rx_r[p] && pipe_full_addr(p) == op.rx_address) begin
                  res.matched_pipe = p[2:0];
                  hit = 1;
               end
            end
         end
         ACT_LOOKUP: begin
            if (op.pipe_index < PIPE_SLOTS) begin
               res.auto_ack_on = en_aa_r[op.pipe_index];
               if (en_rx_r[op.pipe_index] && (!op.need_auto_ack || res.auto_ack_on))
                  res.lookup_addr = pipe_full_addr(int'(op.pipe_index));
            end
         end
         ACT_LOST_INC: begin
            if (observe_r[7:4] != COUNT_MAX) observe_r[7:4] = observe_r[7:4] + 4'd1;
         end
         ACT_RETRY_INC: begin
            if (observe_r[3:0] != COUNT_MAX) observe_r[3:0] = observe_r[3:0] + 4'd1;
         end
         ACT_TXFULL_SET: begin
            fifo_r[5]   = 1'b1;
            status_r[0] = 1'b1;
         end
         ACT_TXFULL_CLR: begin
            fifo_r[5]   = 1'b0;
            status_r[0] = 1'b0;
         end
         ACT_CE_HIGH: begin
            res.chip_enable_changed = ~ce_r;
            ce_r = 1'b1;
         end
         ACT_CE_LOW: begin
            res.chip_enable_changed = ce_r;
            ce_r = 1'b0;
         end
         default: ;
      endcase
      res.irq_active  = |(status_r & ~cfg_r & STATUS_IRQ_MASK);
      res.chip_enable = ce_r;
   endtask

   // queue a request and track the pipe addresses it programs
   task automatic add_op(input logic [3:0] act, input logic [4:0] addr,
                         input logic [39:0] wdata, input logic [39:0] rx,
                         input logic [2:0] pipe, input logic need);
      radio_item_type it;
      it.op.action        = act;
      it.op.reg_addr      = addr;
      it.op.write_data    = wdata;
      it.op.rx_address    = rx;
      it.op.pipe_index    = pipe;
      it.op.need_auto_ack = need;
      it.drain            = hold_next;
      hold_next = 0;
      if (act == ACT_WRITE) begin
         if (addr == REG_RX_ADDR_P0) gen_p0 = wdata;
         else if (addr == REG_RX_ADDR_P1) gen_p1 = wdata;
         else if (addr >= REG_RX_ADDR_P2 && addr <= REG_RX_ADDR_P5)
            gen_low[addr[1:0]] = wdata[7:0];
      end
      pending_ops.push_back(it);
   endtask

   // request driver: predict on each transfer, then load the next item
   always @(posedge clock) begin : req_driver
      radio_rsp_type  want;
      radio_item_type nxt;
      if (ops_sent * 3 < total_ops) begin
         send_idle = 9;
         recv_idle = 49;
      end else if (ops_sent * 3 < total_ops * 2) begin
         send_idle = 49;
         recv_idle = 9;
      end else begin
         send_idle = 0;
         recv_idle = 0;
      end
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            radio_regs_step(cur_op, want);
            expected_rsps.push_back(want);
            ops_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_ops.size() != 0 &&
                !(pending_ops[0].drain && expected_rsps.size() != 0) &&
                $urandom_range(0, 99) >= send_idle) begin
               nxt = pending_ops.pop_front();
               cur_op = nxt.op;
               req_tdata  <= {7'b0, cur_op.need_auto_ack, cur_op.pipe_index,
                              cur_op.rx_address, cur_op.write_data, cur_op.reg_addr};
               req_tuser  <= cur_op.action;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor and receiver backpressure
   always @(posedge clock) begin : rsp_monitor
      radio_rsp_type got;
      radio_rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[88:0];
            if (expected_rsps.size() == 0) begin
               report_mismatch("response transfer with no request outstanding");
            end else begin
               want = expected_rsps.pop_front();
               if (got.read_data !== want.read_data)
                  report_mismatch($sformatf("read_data %h, expected %h",
                                            got.read_data, want.read_data));
               if (got.matched_pipe !== want.matched_pipe)
                  report_mismatch($sformatf("matched_pipe %0d, expected %0d",
                                            got.matched_pipe, want.matched_pipe));
               if (got.lookup_addr !== want.lookup_addr)
                  report_mismatch($sformatf("lookup_addr %h, expected %h",
                                            got.lookup_addr, want.lookup_addr));
               if (got.auto_ack_on !== want.auto_ack_on)
                  report_mismatch($sformatf("auto_ack_on %b, expected %b",
                                            got.auto_ack_on, want.auto_ack_on));
               if (got.irq_active !== want.irq_active)
                  report_mismatch($sformatf("irq_active %b, expected %b",
                                            got.irq_active, want.irq_active));
               if (got.mode_changed !== want.mode_changed)
                  report_mismatch($sformatf("mode_changed %b, expected %b",
                                            got.mode_changed, want.mode_changed));
               if (got.power_changed !== want.power_changed)
                  report_mismatch($sformatf("power_changed %b, expected %b",
                                            got.power_changed, want.power_changed));
               if (got.chip_enable_changed !== want.chip_enable_changed)
                  report_mismatch($sformatf("chip_enable_changed %b, expected %b",
                                            got.chip_enable_changed,
                                            want.chip_enable_changed));
               if (got.chip_enable !== want.chip_enable)
                  report_mismatch($sformatf("chip_enable %b, expected %b",
                                            got.chip_enable, want.chip_enable));
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle);
      end
   end

   // watchdog
   initial begin : watchdog
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("TEST FAILED");
      $finish;
   end

   // stimulus and end of run
   initial begin : stimulus
      int          n, k, p, j, n_target, next_drain;
      logic [39:0] rx;

      // mirror reset state
      cfg_r      = RST_CONFIG;
      en_aa_r    = RST_EN_AA;
      en_rx_r    = RST_EN_RXADDR;
      setup_r[0] = RST_SETUP_AW;
      setup_r[1] = RST_SETUP_RETR;
      setup_r[2] = RST_RF_CH;
      setup_r[3] = RST_RF_SETUP;
      status_r   = RST_STATUS;
      observe_r  = '0;
      fifo_r     = RST_FIFO_STATUS;
      wide_r[0]  = RST_ADDR_P0;
      wide_r[1]  = RST_ADDR_P1;
      wide_r[2]  = RST_ADDR_TX;
      low_r[0]   = RST_LOW_P2;
      low_r[1]   = RST_LOW_P3;
      low_r[2]   = RST_LOW_P4;
      low_r[3]   = RST_LOW_P5;
      for (k = 0; k < 6; k++) rx_pw_r[k] = '0;
      dyn_r[0]   = '0;
      dyn_r[1]   = '0;
      ce_r       = 1'b0;
      gen_p0     = RST_ADDR_P0;
      gen_p1     = RST_ADDR_P1;
      for (k = 0; k < 4; k++) gen_low[k] = low_r[k];

      // directed: reset values, read-only and unmapped addresses, pipe 2 gated
      // by its enable, lookup of a missing pipe, counters, tx full, ce edges
      add_op(ACT_READ, REG_CONFIG, '0, '0, 3'd0, 1'b0);
      add_op(ACT_READ, REG_RPD, '0, '0, 3'd0, 1'b0);
      add_op(ACT_READ, REG_UNMAPPED_HI, '1, '1, 3'd7, 1'b1);
      add_op(ACT_MATCH, REG_CONFIG, '0, RST_ADDR_P0, 3'd0, 1'b0);
      add_op(ACT_MATCH, REG_CONFIG, '0, {RST_ADDR_P1[39:8], RST_LOW_P2}, 3'd0, 1'b0);
      add_op(ACT_WRITE, REG_EN_RXADDR, '1, '0, 3'd0, 1'b0);
      add_op(ACT_MATCH, REG_CONFIG, '0, {RST_ADDR_P1[39:8], RST_LOW_P2}, 3'd0, 1'b0);
      add_op(ACT_LOOKUP, REG_CONFIG, '0, '0, 3'd5, 1'b1);
      add_op(ACT_LOOKUP, REG_CONFIG, '0, '0, 3'd7, 1'b0);
      add_op(ACT_WRITE, REG_EN_AA, '0, '0, 3'd0, 1'b0);
      add_op(ACT_LOOKUP, REG_CONFIG, '0, '0, 3'd1, 1'b1);
      add_op(ACT_WRITE, REG_RX_ADDR_P1, '1, '0, 3'd0, 1'b0);
      add_op(ACT_LOOKUP, REG_CONFIG, '0, '0, 3'd4, 1'b0);
      add_op(ACT_WRITE, REG_STATUS, '1, '0, 3'd0, 1'b0);
      add_op(ACT_WRITE, REG_CONFIG, '1, '0, 3'd0, 1'b0);
      add_op(ACT_WRITE, REG_CONFIG, '0, '0, 3'd0, 1'b0);
      add_op(ACT_WRITE, REG_OBSERVE_TX, '1, '0, 3'd0, 1'b0);
      add_op(ACT_WRITE, REG_FIFO_STATUS, '0, '0, 3'd0, 1'b0);
      add_op(ACT_WRITE, REG_UNMAPPED_LO, '1, '0, 3'd0, 1'b0);
      add_op(ACT_LOST_INC, REG_CONFIG, '0, '0, 3'd0, 1'b0);
      add_op(ACT_RETRY_INC, REG_CONFIG, '0, '0, 3'd0, 1'b0);
      add_op(ACT_WRITE, REG_RF_CH, 40'h7F, '0, 3'd0, 1'b0);
      add_op(ACT_READ, REG_OBSERVE_TX, '0, '0, 3'd0, 1'b0);
      add_op(ACT_TXFULL_SET, REG_CONFIG, '0, '0, 3'd0, 1'b0);
      add_op(ACT_READ, REG_FIFO_STATUS, '0, '0, 3'd0, 1'b0);
      add_op(ACT_TXFULL_CLR, REG_CONFIG, '0, '0, 3'd0, 1'b0);
      add_op(ACT_CE_HIGH, REG_CONFIG, '0, '0, 3'd0, 1'b0);
      add_op(ACT_CE_HIGH, REG_CONFIG, '0, '0, 3'd0, 1'b0);
      add_op(ACT_CE_LOW, REG_CONFIG, '0, '0, 3'd0, 1'b0);
      add_op(ACT_UNUSED_HI, REG_UNMAPPED_LO, '1, '1, 3'd7, 1'b1);

      // random sequences
      n_target   = pending_ops.size() + RANDOM_OPS;
      next_drain = pending_ops.size() + DRAIN_EVERY;
      while (pending_ops.size() < n_target) begin
         if (pending_ops.size() >= next_drain) begin
            hold_next  = 1;
            next_drain = next_drain + DRAIN_EVERY;
         end
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               // reprogram pipes, then match and lookup traffic near them
               if ($urandom_range(0, 1))
                  add_op(ACT_WRITE, REG_EN_RXADDR, rand40(), rand40(),
                         rand_pipe(), rand_bit());
               if ($urandom_range(0, 2) == 0)
                  add_op(ACT_WRITE, REG_EN_AA, rand40(), rand40(),
                         rand_pipe(), rand_bit());
               if ($urandom_range(0, 2) == 0)
                  add_op(ACT_WRITE, 5'(REG_RX_ADDR_P0 + $urandom_range(0, 5)), rand40(),
                         rand40(), rand_pipe(), rand_bit());
               n = $urandom_range(3, 8);
               for (k = 0; k < n; k++) begin
                  p  = $urandom_range(0, 5);
                  rx = gen_pipe(p);
                  j  = $urandom_range(0, 39);
                  case ($urandom_range(0, 3))
                     0: rx = rand40();
                     1: rx[j] = ~rx[j];
                     default: ;
                  endcase
                  if ($urandom_range(0, 2) == 0)
                     add_op(ACT_LOOKUP, rand_reg(), rand40(), rx,
                            rand_pipe(), rand_bit());
                  else
                     add_op(ACT_MATCH, rand_reg(), rand40(), rx,
                            rand_pipe(), rand_bit());
               end
            end
            4: begin
               // counter burst, long enough to saturate now and then
               n = $urandom_range(5, 20);
               for (k = 0; k < n; k++)
                  add_op($urandom_range(0, 1) ? ACT_LOST_INC : ACT_RETRY_INC,
                         rand_reg(), rand40(), rand40(),
                         rand_pipe(), rand_bit());
               add_op(ACT_READ, REG_OBSERVE_TX, rand40(), rand40(), 3'd0, 1'b0);
               if ($urandom_range(0, 1)) begin
                  add_op(ACT_WRITE, REG_RF_CH, rand40(), rand40(), 3'd0, 1'b0);
                  add_op(ACT_READ, REG_OBSERVE_TX, rand40(), rand40(), 3'd0, 1'b0);
               end
            end
            5: begin
               // config, status and tx full
               add_op(ACT_WRITE, REG_CONFIG, rand40(), rand40(), 3'd0, 1'b0);
               add_op(ACT_WRITE, REG_STATUS, rand40(), rand40(), 3'd0, 1'b0);
               add_op(ACT_READ, REG_STATUS, rand40(), rand40(), 3'd0, 1'b0);
               add_op($urandom_range(0, 1) ? ACT_TXFULL_SET : ACT_TXFULL_CLR,
                      rand_reg(), rand40(), rand40(), 3'd0, 1'b0);
               add_op(ACT_READ, REG_FIFO_STATUS, rand40(), rand40(), 3'd0, 1'b0);
               add_op(ACT_READ, REG_CONFIG, rand40(), rand40(), 3'd0, 1'b0);
            end
            6: begin
               n = $urandom_range(2, 5);
               for (k = 0; k < n; k++)
                  add_op($urandom_range(0, 1) ? ACT_CE_HIGH : ACT_CE_LOW,
                         rand_reg(), rand40(), rand40(),
                         rand_pipe(), rand_bit());
            end
            7: begin
               // write then read back one register
               j = $urandom_range(0, 31);
               add_op(ACT_WRITE, 5'(j), rand40(), rand40(), rand_pipe(), rand_bit());
               add_op(ACT_READ, 5'(j), rand40(), rand40(), rand_pipe(), rand_bit());
            end
            default: begin
               add_op(4'($urandom_range(0, 15)), rand_reg(), rand40(), rand40(),
                      rand_pipe(), rand_bit());
            end
         endcase
      end
      total_ops = pending_ops.size();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // wait for the last response, then keep watching for strays
      do
         @(negedge clock);
      while (pending_ops.size() != 0 || req_tvalid || expected_rsps.size() != 0);
      repeat (8) @(negedge clock);

      if (errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

/* sim.f */
rtl/rrfpm_pkg.sv
rtl/rrfpm_regs.sv
rtl/rrfpm_match.sv
rtl/radio_register_file_pipe_match_core.sv
rtl/rrfpm_checker.sv
tb/radio_register_file_pipe_match_core_test.sv
